>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the tilt angle band classifier.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in tilt classifier");

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in tilt classifier");

`endif

>>> hdl/tabc_pkg.sv
// Package for the tilt angle band classifier: widths, the arctangent table,
// pipeline payload types and register and band codes. No dependencies.
`timescale 1ns / 1ps

package tabc_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;

    localparam int AXIS_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int ACC_FRAC = 24;
    localparam int GUARD    = 16;
    localparam int RAD_W    = 2 * AXIS_W;
    localparam int ROOT_W   = AXIS_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int CW       = 35;
    localparam int Z_W      = 32;
    localparam int ATAN_LEN = 24;
    localparam int IDX_W    = $clog2(ATAN_LEN);

    localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [Z_W-1:0] TILT_LIMIT = Z_W'(90) << ANGLE_FRAC_BITS;

    localparam logic [LIMIT_W-1:0] LOWER_RESET = LIMIT_W'(3840);
    localparam logic [LIMIT_W-1:0] UPPER_RESET = LIMIT_W'(7680);

    // Register indexes on the configuration port.
    localparam logic REG_LOWER = 1'b0;
    localparam logic REG_UPPER = 1'b1;

    typedef enum logic [1:0] {
        BAND_GREEN = 2'd0,
        BAND_BLUE  = 2'd1,
        BAND_RED   = 2'd2
    } band_t;

    // atan(2^-i) in degrees with ACC_FRAC fraction bits, rounded to nearest.
    localparam logic signed [Z_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    // Payload passed between square-root cells.
    typedef struct packed {
        logic [RAD_W-1:0]         rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [AXIS_W-1:0] ax;
    } sqrt_bus_t;

    // Payload passed between CORDIC cells.
    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [Z_W-1:0] z;
        logic                  zero;
    } cordic_bus_t;

endpackage

>>> hdl/tabc_if.sv
// Channel interfaces of the tilt angle band classifier: the sample channel
// and the result channel. Depends on tabc_pkg.
`timescale 1ns / 1ps

interface tabc_sample_if import tabc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface tabc_result_if import tabc_pkg::*;;
    logic              valid;
    logic              ready;
    logic signed [15:0] tilt_degrees;
    logic [1:0]        band_class;

    modport source (output valid, output tilt_degrees, output band_class, input ready);
    modport sink   (input valid, input tilt_degrees, input band_class, output ready);
endinterface

>>> hdl/tilt_angle_band_classifier_top.sv
// Throughput: one sample per cycle; every stage of the square-root and CORDIC chains
// is a registered cell, so a new sample enters each cycle the skid register is empty.
// Reset clears all valid flags, including those of the output and skid registers, and
// restores the band limits to 15 and 30 degrees.
// Depends on tabc_pkg, tabc_if, tabc_sqrt_cell, tabc_cordic_cell and assert_macros.svh.
`timescale 1ns / 1ps

module tilt_angle_band_classifier_top import tabc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    tabc_sample_if.sink        samples,
    tabc_result_if.source      results
);

    logic [LIMIT_W-1:0] lower_reg;
    logic [LIMIT_W-1:0] upper_reg;

    logic                     en;
    logic                     sq_valid_reg;
    logic [RAD_W-2:0]         ay_sq_reg;
    logic [RAD_W-2:0]         az_sq_reg;
    logic signed [AXIS_W-1:0] ax_reg;
    logic signed [RAD_W-1:0]  ay_prod;
    logic signed [RAD_W-1:0]  az_prod;

    logic        sqrt_valid [ROOT_W+1];
    sqrt_bus_t   sqrt_bus   [ROOT_W+1];
    logic        cor_valid  [CORDIC_STAGES+1];
    cordic_bus_t cor_bus    [CORDIC_STAGES+1];

    logic signed [Z_W-1:0] z_rnd;
    logic signed [Z_W-1:0] q_shift;
    logic signed [Z_W-1:0] q_sat;
    logic signed [Z_W-1:0] lower_ext;
    logic signed [Z_W-1:0] upper_ext;
    band_t                 band_next;

    logic               out_valid_reg;
    logic signed [15:0] out_tilt_reg;
    band_t              out_band_reg;
    logic               skid_valid_reg;
    logic signed [15:0] skid_tilt_reg;
    band_t              skid_band_reg;
    logic               exit_valid;
    logic               out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LOWER: lower_reg <= cfg_data;
                REG_UPPER: upper_reg <= cfg_data;
                default:   lower_reg <= lower_reg;
            endcase
        end
    end

    // The whole chain moves together while the skid register is empty.
    assign en            = !skid_valid_reg;
    assign samples.ready = en;

    assign ay_prod = samples.accel_y * samples.accel_y;
    assign az_prod = samples.accel_z * samples.accel_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ay_sq_reg <= ay_prod[RAD_W-2:0];
            az_sq_reg <= az_prod[RAD_W-2:0];
            ax_reg    <= samples.accel_x;
        end
    end

    // Square-root chain: one root bit per cell, most significant first.
    assign sqrt_valid[0] = sq_valid_reg;
    assign sqrt_bus[0]   = '{rad:  {1'b0, ay_sq_reg} + {1'b0, az_sq_reg},
                             rem:  '0,
                             root: '0,
                             ax:   ax_reg};

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        tabc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sqrt_valid[i]),
            .din       (sqrt_bus[i]),
            .out_valid (sqrt_valid[i+1]),
            .dout      (sqrt_bus[i+1])
        );
    end

    // CORDIC chain, starting from (r, ax) scaled by the guard bits.
    assign cor_valid[0]    = sqrt_valid[ROOT_W];
    assign cor_bus[0].x    = {{(CW-ROOT_W-GUARD){1'b0}}, sqrt_bus[ROOT_W].root, {GUARD{1'b0}}};
    assign cor_bus[0].y    = {{(CW-AXIS_W-GUARD){sqrt_bus[ROOT_W].ax[AXIS_W-1]}},
                              sqrt_bus[ROOT_W].ax, {GUARD{1'b0}}};
    assign cor_bus[0].z    = '0;
    assign cor_bus[0].zero = (sqrt_bus[ROOT_W].root == '0) && (sqrt_bus[ROOT_W].ax == '0);

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        tabc_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_idx (IDX_W'(i)),
            .in_valid  (cor_valid[i]),
            .din       (cor_bus[i]),
            .out_valid (cor_valid[i+1]),
            .dout      (cor_bus[i+1])
        );
    end

    // Rounding, saturation and band decision on the chain's last cell.
    always_comb
    begin
        z_rnd     = cor_bus[CORDIC_STAGES].z + ROUND_HALF;
        q_shift   = z_rnd >>> RND_SHIFT;
        lower_ext = $signed({{(Z_W-LIMIT_W){1'b0}}, lower_reg});
        upper_ext = $signed({{(Z_W-LIMIT_W){1'b0}}, upper_reg});
        if (cor_bus[CORDIC_STAGES].zero)
        begin
            q_sat = '0;
        end
        else if (q_shift > TILT_LIMIT)
        begin
            q_sat = TILT_LIMIT;
        end
        else if (q_shift < -TILT_LIMIT)
        begin
            q_sat = -TILT_LIMIT;
        end
        else
        begin
            q_sat = q_shift;
        end
        if (q_sat > upper_ext)
        begin
            band_next = BAND_RED;
        end
        else if (q_sat >= lower_ext)
        begin
            band_next = BAND_BLUE;
        end
        else
        begin
            band_next = BAND_GREEN;
        end
    end

    // Output register with a one-entry skid register behind it.
    assign exit_valid = en && cor_valid[CORDIC_STAGES];
    assign out_free   = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= exit_valid;
            end
        end
        else if (exit_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_tilt_reg <= skid_tilt_reg;
                out_band_reg <= skid_band_reg;
            end
            else if (exit_valid)
            begin
                out_tilt_reg <= q_sat[15:0];
                out_band_reg <= band_next;
            end
        end
        else if (exit_valid)
        begin
            skid_tilt_reg <= q_sat[15:0];
            skid_band_reg <= band_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.tilt_degrees = out_tilt_reg;
    assign results.band_class   = out_band_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPL(a_skid_blocks_input, skid_valid_reg, !samples.ready)
    `ASSERT_NEXT(a_skid_fill_on_stall, out_valid_reg && !results.ready && exit_valid,
                 skid_valid_reg && out_valid_reg)

endmodule

>>> hdl/tabc_sqrt_cell.sv
// One cell of the integer square-root chain: settles one bit of the root.
// Depends on tabc_pkg.
`timescale 1ns / 1ps

module tabc_sqrt_cell import tabc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  sqrt_bus_t din,
    output logic      out_valid,
    output sqrt_bus_t dout
);

    logic             valid_reg;
    sqrt_bus_t        data_reg;
    sqrt_bus_t        data_next;
    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;

    always_comb
    begin
        cand  = {din.rem, din.rad[RAD_W-1 -: 2]};
        trial = {2'b00, din.root, 2'b01};
        data_next     = din;
        data_next.rad = din.rad << 2;
        if (cand >= trial)
        begin
            data_next.rem  = REM_W'(cand - trial);
            data_next.root = {din.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = REM_W'(cand);
            data_next.root = {din.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = data_reg;

endmodule

>>> hdl/tabc_cordic_cell.sv
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
// Depends on tabc_pkg for the arctangent table and payload type.
`timescale 1ns / 1ps

module tabc_cordic_cell import tabc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [IDX_W-1:0] stage_idx,
    input  logic             in_valid,
    input  cordic_bus_t      din,
    output logic             out_valid,
    output cordic_bus_t      dout
);

    logic                  valid_reg;
    cordic_bus_t           data_reg;
    cordic_bus_t           data_next;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [Z_W-1:0] angle;

    always_comb
    begin
        // Arithmetic shifts round toward minus infinity.
        dx    = din.y >>> stage_idx;
        dy    = din.x >>> stage_idx;
        angle = ATAN_TABLE[stage_idx];
        data_next = din;
        if (!din.y[CW-1])
        begin
            data_next.x = din.x + dx;
            data_next.y = din.y - dy;
            data_next.z = din.z + angle;
        end
        else
        begin
            data_next.x = din.x - dx;
            data_next.y = din.y + dy;
            data_next.z = din.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = data_reg;

endmodule
